// ----- design/fpbsc_pkg.sv -----
// Shared constants, types and the quarter-wave sine table for the FFT peak/centroid block.
// Used by every module of the block; no dependencies of its own.
package fpbsc_pkg;

   localparam int MAX_LOG2  = 10;
   localparam int MIN_LOG2  = 2;
   localparam int MAX_POINTS = 1 << MAX_LOG2;
   localparam int ADDR_W    = MAX_LOG2;
   localparam int TW_IDX_W  = MAX_LOG2 - 1;
   localparam int QTR       = MAX_POINTS / 4;
   localparam int LG_W      = 4;
   localparam int SAMPLE_W  = 16;
   localparam int HALF_W    = 27;
   localparam int TW_W      = 17;
   localparam int MUL_W     = 28;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int ACC_W     = PROD_W + 1;
   localparam int PR_W      = ACC_W - 15;
   localparam int SQ_W      = 2 * HALF_W + 1;
   localparam int MAG_W     = 28;
   localparam int DEN_W     = MAG_W + ADDR_W - 1;
   localparam int NUM_W     = MAG_W + 2 * (ADDR_W - 1);
   localparam int CENT_FRAC = 16;
   localparam int NUMER_W   = NUM_W + CENT_FRAC - MIN_LOG2;
   localparam int QUOT_W    = 16;
   localparam int BIN_W     = 9;
   localparam int CENT_W    = 15;

   localparam logic [63:0] Q30_TWO_PI = 64'd6746518852;

   // Taylor divisors (2n)(2n+1) for n = 1..12
   localparam logic [63:0] SIN_DIV [1:12] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
      64'd156, 64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

   typedef logic [TW_W-1:0] qsin_tab_type [0:QTR];

   // Elaboration-time sine table, Q15 rounded, in Q30 integer series form
   function automatic qsin_tab_type make_qsin();
      qsin_tab_type tab;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [64:0] sum;
      for (int k = 0; k <= QTR; k++) begin
         x = (64'(k) * Q30_TWO_PI) / MAX_POINTS;
         x2 = (x * x) >> 30;
         term = x;
         sum = $signed({1'b0, x});
         for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / SIN_DIV[n];
            if ((n % 2) == 1) begin
               sum = sum - $signed({1'b0, term});
            end else begin
               sum = sum + $signed({1'b0, term});
            end
         end
         if (sum < 0) begin
            sum = '0;
         end
         tab[k] = TW_W'((64'(sum) + 64'd16384) >> 15);
      end
      return tab;
   endfunction

   localparam qsin_tab_type QSIN = make_qsin();

endpackage

// ----- design/fpbsc_sqrt.sv -----
// Bit-pair iterative floor square root, one result bit per cycle.
// Depends on fpbsc_pkg for widths.
module fpbsc_sqrt import fpbsc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SQ_W-1:0]  radicand,
   output logic             done,
   output logic [MAG_W-1:0] root
);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [SQ_W:0]   res_ff, res_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic [SQ_W:0]   trial;

   always_comb begin
      trial = res_ff + {1'b0, bit_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in = radicand;
         res_in = '0;
         bit_in = SQ_W'(1) << (SQ_W - 1);
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - SQ_W'(trial);
            res_in = (res_ff >> 1) + {1'b0, bit_ff};
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         // last bit pair: finish
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[MAG_W-1:0];

endmodule

// ----- design/fpbsc_div.sv -----
// Restoring divider, one quotient bit per cycle, for the centroid ratio.
// Depends on fpbsc_pkg for widths.
module fpbsc_div import fpbsc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUMER_W-1:0] numer,
   input  logic [DEN_W-1:0]   denom,
   output logic               done,
   output logic [CENT_W-1:0]  quot
);

   localparam int DSH_W = DEN_W + QUOT_W - 1;
   localparam int CNT_W = $clog2(QUOT_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [NUMER_W-1:0] rem_ff, rem_in;
   logic [DSH_W-1:0]   dsh_ff, dsh_in;
   logic [QUOT_W-1:0]  q_ff, q_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               fits;

   always_comb begin
      fits = rem_ff >= NUMER_W'(dsh_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in = numer;
         dsh_in = DSH_W'(denom) << (QUOT_W - 1);
         q_in = '0;
         cnt_in = CNT_W'(QUOT_W - 1);
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - NUMER_W'(dsh_ff);
         end
         q_in = {q_ff[QUOT_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = q_ff[CENT_W-1:0];

endmodule

// ----- design/fft_peak_bin_and_spectral_centroid.sv -----
// FFT peak bin and spectral centroid: top level with sequencer, spectrum memory and multiplier.
// Depends on fpbsc_pkg, fpbsc_sqrt and fpbsc_div.
//
// Usage:
//   req_* carries one signed 16-bit sample per beat. A frame is N = 2^L samples,
//   L = csr_points_log2 clamped to 2..10. Samples load at one beat per cycle.
//   The last sample of a frame starts processing; req_stall stays high until done.
//   Processing: (N/2)*L butterflies, each a read, four products through one
//   shared multiplier and writes of both outputs, then a magnitude pass over N/2
//   bins (squares, square root unit at one bit per cycle), then the division.
//   rsp_* then carries one beat: dominant_bin and centroid_q16. The result sits
//   in an output register, so the next frame loads while it waits; a new result
//   holds in the final step until the receiver drops rsp_stall.
//   csr_* writes points_log2 (always ready); a write discards a partial frame.
//   Write it only while the block is idle.
//   Reset (synchronous) clears the sample count, sets points_log2 to 10 and
//   drops rsp_valid. The spectrum memory is not cleared: every frame writes
//   its N entries before it reads any.
module fft_peak_bin_and_spectral_centroid import fpbsc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BIN_W-1:0]    rsp_dominant_bin,
   output logic [CENT_W-1:0]   rsp_centroid_q16,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LG_W-1:0]     csr_points_log2
);

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] ST_LOAD   = 5'd0;
   localparam logic [ST_W-1:0] ST_BF_RD  = 5'd1;
   localparam logic [ST_W-1:0] ST_BF_M0  = 5'd2;
   localparam logic [ST_W-1:0] ST_BF_M1  = 5'd3;
   localparam logic [ST_W-1:0] ST_BF_M2  = 5'd4;
   localparam logic [ST_W-1:0] ST_BF_M3  = 5'd5;
   localparam logic [ST_W-1:0] ST_BF_M4  = 5'd6;
   localparam logic [ST_W-1:0] ST_BF_WE  = 5'd7;
   localparam logic [ST_W-1:0] ST_BF_WO  = 5'd8;
   localparam logic [ST_W-1:0] ST_MG_RD  = 5'd9;
   localparam logic [ST_W-1:0] ST_MG_M0  = 5'd10;
   localparam logic [ST_W-1:0] ST_MG_M1  = 5'd11;
   localparam logic [ST_W-1:0] ST_MG_M2  = 5'd12;
   localparam logic [ST_W-1:0] ST_MG_SQ  = 5'd13;
   localparam logic [ST_W-1:0] ST_MG_SW  = 5'd14;
   localparam logic [ST_W-1:0] ST_MG_ACC = 5'd15;
   localparam logic [ST_W-1:0] ST_MG_ADD = 5'd16;
   localparam logic [ST_W-1:0] ST_DIV    = 5'd17;
   localparam logic [ST_W-1:0] ST_DIV_W  = 5'd18;
   localparam logic [ST_W-1:0] ST_OUT    = 5'd19;

   localparam int MEM_W = 2 * HALF_W;
   localparam int BIDX_W = ADDR_W - 1;
   localparam logic signed [PR_W:0] SAT_HI = (PR_W + 1)'((1 << (HALF_W - 1)) - 1);
   localparam logic signed [PR_W:0] SAT_LO = -(PR_W + 1)'(1 << (HALF_W - 1));

   function automatic logic signed [HALF_W-1:0] sat_half(input logic signed [PR_W:0] v);
      logic signed [HALF_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[HALF_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[HALF_W-1:0];
      end else begin
         r = v[HALF_W-1:0];
      end
      return r;
   endfunction

   // control registers
   logic [ST_W-1:0]   state_ff, state_in;
   logic [LG_W-1:0]   lg_cfg_ff, lg_cfg_in;
   logic [ADDR_W-1:0] count_ff, count_in;
   logic [LG_W-1:0]   stage_ff, stage_in;
   logic [BIDX_W-1:0] bidx_ff, bidx_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic signed [TW_W-1:0]   wr_ff, wr_in, wi_ff, wi_in;
   logic [MEM_W-1:0]         rd_e_ff, rd_o_ff;
   logic signed [PROD_W-1:0] mul_ff;
   logic signed [ACC_W-1:0]  accr_ff, accr_in, acci_ff, acci_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [MAG_W-1:0]         mag_ff, mag_in, max_ff, max_in;
   logic [BIDX_W-1:0]        dom_ff, dom_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [CENT_W-1:0]        cent_ff, cent_in;
   logic [BIN_W-1:0]         rsp_dom_ff, rsp_dom_in;
   logic [CENT_W-1:0]        rsp_cent_ff, rsp_cent_in;

   logic [MEM_W-1:0] mem [0:MAX_POINTS-1];

   logic [LG_W-1:0]   eff_lg;
   logic [ADDR_W-1:0] cnt_last;
   logic [BIDX_W-1:0] bidx_last;
   logic [ADDR_W-1:0] rev_cnt, load_addr;
   logic [ADDR_W-1:0] hbit, hmask, b10, jpos, e_addr, o_addr;
   logic [TW_IDX_W-1:0] tw_idx;
   logic [ADDR_W-1:0] tw_far;
   logic signed [TW_W:0] c_raw, s_raw;
   logic load_acc, mem_we, rd_en;
   logic [ADDR_W-1:0] mem_wa, ra_e;
   logic [MEM_W-1:0]  mem_wd;
   logic signed [HALF_W-1:0] ar, ai, br, bi, mre, mim;
   logic signed [PR_W-1:0] pr, pi;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic sqrt_start, sqrt_done, div_start, div_done;
   logic [MAG_W-1:0] sqrt_root;
   logic [CENT_W-1:0] div_quot;
   logic [LG_W-1:0] cshift;
   logic [NUMER_W-1:0] numer;

   // effective frame size
   always_comb begin
      priority if (lg_cfg_ff < LG_W'(MIN_LOG2)) begin
         eff_lg = LG_W'(MIN_LOG2);
      end else if (lg_cfg_ff > LG_W'(MAX_LOG2)) begin
         eff_lg = LG_W'(MAX_LOG2);
      end else begin
         eff_lg = lg_cfg_ff;
      end
   end

   assign cnt_last  = ADDR_W'(((ADDR_W + 1)'(1) << eff_lg) - 1'b1);
   assign bidx_last = BIDX_W'((ADDR_W'(1) << (eff_lg - 1'b1)) - 1'b1);

   // samples land at bit-reversed addresses so the butterflies run in place
   always_comb begin
      for (int b = 0; b < ADDR_W; b++) begin
         rev_cnt[b] = count_ff[ADDR_W-1-b];
      end
      load_addr = rev_cnt >> (LG_W'(ADDR_W) - eff_lg);
   end

   // butterfly addressing: half span h = 2^(stage-1)
   always_comb begin
      hbit   = ADDR_W'(1) << (stage_ff - 1'b1);
      hmask  = hbit - 1'b1;
      b10    = {1'b0, bidx_ff};
      jpos   = b10 & hmask;
      e_addr = ((b10 & ~hmask) << 1) | jpos;
      o_addr = e_addr | hbit;
      tw_idx = TW_IDX_W'(jpos << (LG_W'(ADDR_W) - stage_ff));
   end

   // twiddle from quarter-wave table
   always_comb begin
      tw_far = ADDR_W'(2 * QTR) - {1'b0, tw_idx};
      if (tw_idx <= TW_IDX_W'(QTR)) begin
         c_raw = $signed({1'b0, QSIN[TW_IDX_W'(QTR) - tw_idx]});
         s_raw = $signed({1'b0, QSIN[tw_idx]});
      end else begin
         c_raw = -$signed({1'b0, QSIN[tw_idx - TW_IDX_W'(QTR)]});
         s_raw = $signed({1'b0, QSIN[tw_far[TW_IDX_W-1:0]]});
      end
      // cos of zero saturates to just under one
      if (c_raw > (TW_W + 1)'((1 << (SAMPLE_W - 1)) - 1)) begin
         wr_in = TW_W'((1 << (SAMPLE_W - 1)) - 1);
      end else begin
         wr_in = c_raw[TW_W-1:0];
      end
      wi_in = TW_W'(-s_raw);
   end

   assign ar  = rd_e_ff[MEM_W-1:HALF_W];
   assign ai  = rd_e_ff[HALF_W-1:0];
   assign br  = rd_o_ff[MEM_W-1:HALF_W];
   assign bi  = rd_o_ff[HALF_W-1:0];
   assign mre = ar;
   assign mim = ai;
   assign pr  = PR_W'(accr_ff >>> 15);
   assign pi  = PR_W'(acci_ff >>> 15);

   assign load_acc = req_valid && !req_stall;
   assign rd_en    = (state_ff == ST_BF_RD) || (state_ff == ST_MG_RD);
   assign ra_e     = (state_ff == ST_MG_RD) ? b10 : e_addr;

   // single write port
   always_comb begin
      mem_we = 1'b0;
      mem_wa = e_addr;
      mem_wd = '0;
      if (load_acc) begin
         mem_we = 1'b1;
         mem_wa = load_addr;
         mem_wd = {HALF_W'(req_sample), HALF_W'(0)};
      end else if (state_ff == ST_BF_WE) begin
         mem_we = 1'b1;
         mem_wa = e_addr;
         mem_wd = {sat_half((PR_W + 1)'(ar) + (PR_W + 1)'(pr)),
                   sat_half((PR_W + 1)'(ai) + (PR_W + 1)'(pi))};
      end else if (state_ff == ST_BF_WO) begin
         mem_we = 1'b1;
         mem_wa = o_addr;
         mem_wd = {sat_half((PR_W + 1)'(ar) - (PR_W + 1)'(pr)),
                   sat_half((PR_W + 1)'(ai) - (PR_W + 1)'(pi))};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_e_ff <= mem[ra_e];
         rd_o_ff <= mem[o_addr];
      end
   end

   // shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_BF_M0: begin
            mul_a = MUL_W'(br);
            mul_b = MUL_W'(wr_ff);
         end
         ST_BF_M1: begin
            mul_a = MUL_W'(bi);
            mul_b = MUL_W'(wi_ff);
         end
         ST_BF_M2: begin
            mul_a = MUL_W'(br);
            mul_b = MUL_W'(wi_ff);
         end
         ST_BF_M3: begin
            mul_a = MUL_W'(bi);
            mul_b = MUL_W'(wr_ff);
         end
         ST_MG_M0: begin
            mul_a = MUL_W'(mre);
            mul_b = MUL_W'(mre);
         end
         ST_MG_M1: begin
            mul_a = MUL_W'(mim);
            mul_b = MUL_W'(mim);
         end
         ST_MG_ACC: begin
            mul_a = $signed(MUL_W'(bidx_ff));
            mul_b = $signed(mag_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   assign cshift = LG_W'(CENT_FRAC) - eff_lg;
   assign numer  = NUMER_W'(num_ff) << cshift;

   fpbsc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   fpbsc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (numer),
      .denom (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign sqrt_start = (state_ff == ST_MG_SQ);
   assign div_start  = (state_ff == ST_DIV) && (den_ff != '0);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      lg_cfg_in    = lg_cfg_ff;
      count_in     = count_ff;
      stage_in     = stage_ff;
      bidx_in      = bidx_ff;
      rsp_valid_in = rsp_valid_ff;
      accr_in      = accr_ff;
      acci_in      = acci_ff;
      sq_in        = sq_ff;
      mag_in       = mag_ff;
      max_in       = max_ff;
      dom_in       = dom_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      cent_in      = cent_ff;
      rsp_dom_in   = rsp_dom_ff;
      rsp_cent_in  = rsp_cent_ff;

      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (load_acc) begin
               if (count_ff == cnt_last) begin
                  count_in = '0;
                  stage_in = LG_W'(1);
                  bidx_in  = '0;
                  state_in = ST_BF_RD;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ST_BF_RD: state_in = ST_BF_M0;
         ST_BF_M0: state_in = ST_BF_M1;
         ST_BF_M1: begin
            accr_in  = ACC_W'(mul_ff);
            state_in = ST_BF_M2;
         end
         ST_BF_M2: begin
            accr_in  = accr_ff - ACC_W'(mul_ff);
            state_in = ST_BF_M3;
         end
         ST_BF_M3: begin
            acci_in  = ACC_W'(mul_ff);
            state_in = ST_BF_M4;
         end
         ST_BF_M4: begin
            acci_in  = acci_ff + ACC_W'(mul_ff);
            state_in = ST_BF_WE;
         end
         ST_BF_WE: state_in = ST_BF_WO;
         ST_BF_WO: begin
            if (bidx_ff == bidx_last) begin
               bidx_in = '0;
               if (stage_ff == eff_lg) begin
                  max_in   = '0;
                  dom_in   = '0;
                  num_in   = '0;
                  den_in   = '0;
                  state_in = ST_MG_RD;
               end else begin
                  stage_in = stage_ff + 1'b1;
                  state_in = ST_BF_RD;
               end
            end else begin
               bidx_in  = bidx_ff + 1'b1;
               state_in = ST_BF_RD;
            end
         end
         ST_MG_RD: state_in = ST_MG_M0;
         ST_MG_M0: state_in = ST_MG_M1;
         ST_MG_M1: begin
            sq_in    = SQ_W'(mul_ff);
            state_in = ST_MG_M2;
         end
         ST_MG_M2: begin
            sq_in    = sq_ff + SQ_W'(mul_ff);
            state_in = ST_MG_SQ;
         end
         ST_MG_SQ: state_in = ST_MG_SW;
         ST_MG_SW: begin
            if (sqrt_done) begin
               mag_in   = sqrt_root;
               state_in = ST_MG_ACC;
            end
         end
         ST_MG_ACC: begin
            den_in = den_ff + DEN_W'(mag_ff);
            // first strict maximum, DC excluded
            if ((bidx_ff != '0) && (mag_ff > max_ff)) begin
               max_in = mag_ff;
               dom_in = bidx_ff;
            end
            state_in = ST_MG_ADD;
         end
         ST_MG_ADD: begin
            num_in = num_ff + NUM_W'(mul_ff);
            if (bidx_ff == bidx_last) begin
               state_in = ST_DIV;
            end else begin
               bidx_in  = bidx_ff + 1'b1;
               state_in = ST_MG_RD;
            end
         end
         ST_DIV: begin
            if (den_ff == '0) begin
               cent_in  = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV_W;
            end
         end
         ST_DIV_W: begin
            if (div_done) begin
               cent_in  = div_quot;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_dom_in   = BIN_W'(dom_ff);
               rsp_cent_in  = cent_ff;
               state_in     = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase

      // a register write restarts the frame
      if (csr_valid && csr_ready) begin
         lg_cfg_in = csr_points_log2;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         lg_cfg_ff    <= LG_W'(MAX_LOG2);
         count_ff     <= '0;
         stage_ff     <= LG_W'(1);
         bidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lg_cfg_ff    <= lg_cfg_in;
         count_ff     <= count_in;
         stage_ff     <= stage_in;
         bidx_ff      <= bidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_BF_RD) begin
         wr_ff <= wr_in;
         wi_ff <= wi_in;
      end
      accr_ff     <= accr_in;
      acci_ff     <= acci_in;
      sq_ff       <= sq_in;
      mag_ff      <= mag_in;
      max_ff      <= max_in;
      dom_ff      <= dom_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      cent_ff     <= cent_in;
      rsp_dom_ff  <= rsp_dom_in;
      rsp_cent_ff <= rsp_cent_in;
   end

   assign req_stall        = (state_ff != ST_LOAD);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dominant_bin = rsp_dom_ff;
   assign rsp_centroid_q16 = rsp_cent_ff;

   a_sqrt_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == ST_MG_SW))
      else $error("square root finished outside its wait step");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_W))
      else $error("divider finished outside its wait step");

   a_count_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (count_ff <= cnt_last))
      else $error("sample count beyond frame length");

   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall))
      |=> (rsp_valid_ff && (state_ff == ST_LOAD)))
      else $error("finished frame did not post a result");

endmodule

// ----- test/tb_fft_peak_bin_and_spectral_centroid.sv -----
// Testbench for fft_peak_bin_and_spectral_centroid: drives sample frames, predicts
// peak bin and centroid with a fixed-point FFT of its own, and checks each result beat.
// Depends on fpbsc_pkg and the block's RTL.
module tb_fft_peak_bin_and_spectral_centroid;
   import fpbsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int SETTLE_CYCLES  = 64;
   localparam int N_RANDOM_ITEMS = 2000;

   typedef struct packed {
      logic [BIN_W-1:0]  bin;
      logic [CENT_W-1:0] cent;
   } peak_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [BIN_W-1:0]           rsp_dominant_bin;
   logic [CENT_W-1:0]          rsp_centroid_q16;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [LG_W-1:0]            csr_points_log2 = '0;

   fft_peak_bin_and_spectral_centroid u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_sample,
      .rsp_valid, .rsp_stall, .rsp_dominant_bin, .rsp_centroid_q16,
      .csr_valid, .csr_ready, .csr_points_log2
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: register copy, frame fill level, working spectrum
   logic [LG_W-1:0] lg_shadow = 4'd10;
   int              fill_level = 0;
   longint          spec_re [0:MAX_POINTS-1];
   longint          spec_im [0:MAX_POINTS-1];
   longint          sine_q15 [0:QTR];
   peak_result_type pending_peaks [$];

   int errors = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int idle_cycles = 0;

   // Quarter-wave sine in Q15, from a Taylor series in Q30
   function automatic void build_sine();
      longint unsigned x, x2, term;
      longint sum;
      for (int k = 0; k <= QTR; k++) begin
         x = (longint'(k) * 64'd6746518852) / MAX_POINTS;
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (int m = 1; m <= 12; m++) begin
            term = ((term * x2) >> 30) / ((2 * m) * (2 * m + 1));
            sum = (m % 2) ? sum - longint'(term) : sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         sine_q15[k] = (sum + 16384) >>> 15;
      end
   endfunction

   function automatic longint sat27(longint v);
      if (v > 64'sd67108863) return 64'sd67108863;
      if (v < -64'sd67108864) return -64'sd67108864;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Transform the held frame in place and reduce it to peak bin and centroid
   function automatic peak_result_type spectral_peak(int lg);
      int n, r, h, stride, t, e, o;
      longint wr, wi, pr, pi, ar, ai, tmp, re, im;
      longint unsigned mag, maxmag, num, den, cent;
      peak_result_type res;
      n = 1 << lg;
      for (int i = 0; i < n; i++) begin
         r = 0;
         for (int b = 0; b < lg; b++) r |= ((i >> b) & 1) << (lg - 1 - b);
         if (r > i) begin
            tmp = spec_re[i]; spec_re[i] = spec_re[r]; spec_re[r] = tmp;
            tmp = spec_im[i]; spec_im[i] = spec_im[r]; spec_im[r] = tmp;
         end
      end
      for (int s = 1; s <= lg; s++) begin
         h = 1 << (s - 1);
         stride = MAX_POINTS >> s;
         for (int base = 0; base < n; base += 2 * h) begin
            for (int j = 0; j < h; j++) begin
               t = j * stride;
               if (t <= QTR) begin
                  wr = sine_q15[QTR - t];
                  wi = -sine_q15[t];
               end else begin
                  wr = -sine_q15[t - QTR];
                  wi = -sine_q15[2 * QTR - t];
               end
               if (wr > 32767) wr = 32767;
               e = base + j;
               o = e + h;
               pr = (spec_re[o] * wr - spec_im[o] * wi) >>> 15;
               pi = (spec_re[o] * wi + spec_im[o] * wr) >>> 15;
               ar = spec_re[e];
               ai = spec_im[e];
               spec_re[e] = sat27(ar + pr);
               spec_im[e] = sat27(ai + pi);
               spec_re[o] = sat27(ar - pr);
               spec_im[o] = sat27(ai - pi);
            end
         end
      end
      maxmag = 0; num = 0; den = 0; cent = 0;
      res.bin = '0;
      for (int i = 0; i < n / 2; i++) begin
         re = spec_re[i];
         im = spec_im[i];
         mag = int_sqrt(longint'(re * re) + longint'(im * im));
         if (i >= 1 && mag > maxmag) begin
            maxmag = mag;
            res.bin = BIN_W'(i);
         end
         num += longint'(i) * mag;
         den += mag;
      end
      if (den != 0) cent = (num << (16 - lg)) / den;
      res.cent = CENT_W'(cent);
      return res;
   endfunction

   // Fold one accepted sample into the frame; a full frame yields an expectation
   function automatic void take_sample(logic signed [SAMPLE_W-1:0] s);
      int lg, n;
      lg = (lg_shadow < MIN_LOG2) ? MIN_LOG2 : (lg_shadow > MAX_LOG2) ? MAX_LOG2 : lg_shadow;
      n = 1 << lg;
      if (fill_level >= n) fill_level = 0;
      spec_re[fill_level] = longint'(s);
      spec_im[fill_level] = 0;
      fill_level++;
      if (fill_level == n) begin
         fill_level = 0;
         pending_peaks.push_back(spectral_peak(lg));
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
   endtask

   // Receiver stall, redrawn each falling edge
   always @(negedge clock) rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);

   // Result checker: compare each accepted beat against the oldest expectation
   always @(posedge clock) begin
      peak_result_type exp_peak;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_peaks.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            exp_peak = pending_peaks.pop_front();
            if (rsp_dominant_bin !== exp_peak.bin)
               report_mismatch($sformatf("dominant_bin %0d, expected %0d",
                  rsp_dominant_bin, exp_peak.bin));
            if (rsp_centroid_q16 !== exp_peak.cent)
               report_mismatch($sformatf("centroid_q16 %0d, expected %0d",
                  rsp_centroid_q16, exp_peak.cent));
         end
      end
   end

   // Watchdog: count cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Send one sample beat; hold valid and payload until accepted
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_sample = s;
      do @(posedge clock); while (req_stall);
      take_sample(s);
   endtask

   // Drop valid, drain all expectations, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_peaks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_points_log2(input logic [LG_W-1:0] v);
      wait_idle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_points_log2 = v;
      do @(posedge clock); while (!csr_ready);
      lg_shadow = v;
      fill_level = 0;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic int frame_len();
      int lg;
      lg = (lg_shadow < MIN_LOG2) ? MIN_LOG2 : (lg_shadow > MAX_LOG2) ? MAX_LOG2 : lg_shadow;
      return 1 << lg;
   endfunction

   // Random content of several flavors: full range, small, extremes, tone
   function automatic logic signed [SAMPLE_W-1:0] pick_sample(int flavor, int k, int period);
      case (flavor)
         0: return SAMPLE_W'($urandom);
         1: return SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
         2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default: return ((k % period) < period / 2) ? 16'sh4000 : -16'sh4000;
      endcase
   endfunction

   // Directed: four-point frames at the sample extremes
   task automatic test_extreme_frames();
      write_points_log2(4'd2);
      repeat (4) send_sample(16'sh7FFF);
      repeat (4) send_sample(16'sh8000);
      repeat (4) send_sample(16'sh0000);
      // energy only at Nyquist, which lies outside the N/2 bins searched
      for (int k = 0; k < 4; k++) send_sample(k[0] ? 16'sh8000 : 16'sh7FFF);
      send_sample(16'sh0000); send_sample(16'sh7FFF);
      send_sample(16'sh0000); send_sample(16'sh8000);
      wait_idle();
   endtask

   // Directed: out-of-range lengths clamp to four points
   task automatic test_length_clamp();
      write_points_log2(4'd0);
      send_sample(16'sh1234); send_sample(-16'sh0100); send_sample(16'sh0001);
      send_sample(16'sh7FFF);
      write_points_log2(4'd1);
      send_sample(16'sh8000); send_sample(16'sh0020); send_sample(16'sh0000);
      send_sample(16'sh5555);
      wait_idle();
   endtask

   // Directed: a write in the middle of a frame discards the partial frame
   task automatic test_midframe_write();
      write_points_log2(4'd3);
      repeat (5) send_sample(16'sh7FFF);
      write_points_log2(4'd2);
      send_sample(16'sh0100); send_sample(16'sh0000);
      send_sample(-16'sh0100); send_sample(16'sh0000);
      wait_idle();
   endtask

   // Random frames under one idling profile; one larger frame in each pass
   task automatic test_random_frames(input int send_idle, input int recv_stall,
                                     input int big_lg, input int n_items);
      int sent, n, flavor, period, cut;
      req_idle_pct = send_idle;
      rsp_stall_pct = recv_stall;
      write_points_log2(LG_W'(big_lg));
      n = frame_len();
      flavor = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) send_sample(pick_sample(flavor, k, 16));
      sent = n;
      while (sent < n_items) begin
         write_points_log2(LG_W'($urandom_range(0, 5)));
         n = frame_len();
         repeat ($urandom_range(1, 4)) begin
            flavor = $urandom_range(0, 3);
            period = 2 << $urandom_range(0, 3);
            // mostly whole frames; now and then a broken one cut short by a write
            if ($urandom_range(0, 9) == 0) begin
               cut = $urandom_range(1, n - 1);
               for (int k = 0; k < cut; k++) begin
                  send_sample(pick_sample(flavor, k, period));
                  sent++;
               end
               break;
            end
            for (int k = 0; k < n; k++) send_sample(pick_sample(flavor, k, period));
            sent += n;
         end
      end
      wait_idle();
   endtask

   initial begin
      build_sine();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extreme_frames();
      test_length_clamp();
      test_midframe_write();
      test_random_frames(7, 78, 15, N_RANDOM_ITEMS / 3);
      test_random_frames(78, 7, 9, N_RANDOM_ITEMS / 3);
      test_random_frames(0, 0, 8, N_RANDOM_ITEMS / 3);
      if (pending_peaks.size() != 0) report_mismatch("expected results never arrived");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
